// ===== design/lkvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and codes for the least-recently-used key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               command;
    logic signed [31:0] lookup_key;
    logic signed [31:0] write_value;
  } lkvc_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } lkvc_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } lkvc_cmd_t;

endpackage
`default_nettype wire

// ===== design/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each item is a get or a set. The key is compared against every entry in the
// cycle the item is accepted; the next cycle updates values and recency ranks
// and registers the result, which then waits for out_ready. No new item is
// accepted until that result is taken. A get miss returns all ones; a set
// returns the written value. Capacity 0 acts as 1, values above MAX_ENTRIES
// act as MAX_ENTRIES; lowering it keeps the entries already held, since each
// later insert replaces the least recent entry. The cache is empty after
// reset.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire lkvc_in_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output lkvc_out_t       out_data
);

  logic [4:0] cap_r;
  lkvc_cmd_t  cmd;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= 5'd16;
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  lkvc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd_o(cmd)
  );

  lkvc_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk, .rst_n, .cap_i(cap_r), .cmd_i(cmd), .item_i(in_data), .result_o(out_data)
  );

endmodule
`default_nettype wire

// ===== design/lkvc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_datapath
// Entry registers, parallel key match, recency ranks and the update logic.
// ----------------------------------------------------------------------------
module lkvc_datapath
  import lkvc_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic [4:0] cap_i,
  input  wire lkvc_cmd_t cmd_i,
  input  wire lkvc_in_t  item_i,
  output lkvc_out_t      result_o
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  logic [31:0]   key_r [MAX_ENTRIES];
  logic [31:0]   val_r [MAX_ENTRIES];
  logic [IW-1:0] rank_r [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_r;
  logic [CW-1:0] count_r;
  lkvc_in_t      item_r;
  // Match results registered in the first cycle.
  logic [MAX_ENTRIES-1:0] match_r;

  logic [MAX_ENTRIES-1:0] match_nxt;
  logic          hit;
  logic [IW-1:0] hit_idx, lru_idx, free_idx, slot;
  logic [CW-1:0] eff_cap;
  logic          full;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_nxt[i] = valid_r[i] && (key_r[i] == item_i.lookup_key);
    end
  end

  always_comb begin
    hit = |match_r;
    hit_idx = '0;
    lru_idx = '0;
    free_idx = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) hit_idx = IW'(i);
      if (!valid_r[i]) free_idx = IW'(i);
      // The least recent entry holds rank count-1.
      if (valid_r[i] && ((CW+1)'(rank_r[i]) == (CW+1)'(count_r) - (CW+1)'(1)))
        lru_idx = IW'(i);
    end
    if (cap_i == 5'd0) eff_cap = CW'(1);
    else if (32'(cap_i) > MAX_ENTRIES) eff_cap = CW'(MAX_ENTRIES);
    else eff_cap = CW'(cap_i);
    full = (count_r >= eff_cap) && (count_r != '0);
    slot = hit ? hit_idx : (full ? lru_idx : free_idx);
  end

  logic          do_upd;
  logic [IW-1:0] old_rank;
  logic          age_all;
  always_comb begin
    do_upd = (item_r.command == CMD_SET) || hit;
    age_all = !hit && !full;
    old_rank = rank_r[slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd_i.commit && do_upd) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IW'(i) == slot) rank_r[i] <= '0;
        else if (valid_r[i] && (age_all || rank_r[i] < old_rank))
          rank_r[i] <= rank_r[i] + IW'(1);
      end
      if (item_r.command == CMD_SET) begin
        key_r[slot] <= item_r.lookup_key;
        val_r[slot] <= item_r.write_value;
      end
      if (age_all) begin
        valid_r[slot] <= 1'b1;
        count_r <= count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      item_r <= item_i;
      match_r <= match_nxt;
    end
    if (cmd_i.commit) begin
      result_o.hit <= hit;
      if (item_r.command == CMD_SET) result_o.read_value <= item_r.write_value;
      else result_o.read_value <= hit ? val_r[hit_idx] : MISS_VALUE;
    end
  end

endmodule
`default_nettype wire

// ===== design/lkvc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer: capture and match, then update and present the result.
// ----------------------------------------------------------------------------
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output lkvc_cmd_t cmd_o
);

  typedef enum logic [1:0] {S_IDLE, S_UPD, S_OUT} state_t;
  state_t state_r, state_nxt;
  logic   out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid;
    in_ready = 1'b0;
    cmd_o = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.commit = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid <= out_valid_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cmd_o.commit |=> out_valid)
    else $error("commit without result");
  assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("accept while result pending");
  assert property (@(posedge clk) disable iff (!rst_n) cmd_o.capture |=> cmd_o.commit)
    else $error("capture not followed by commit");

endmodule
`default_nettype wire
